### design/pife_pkg.sv
`default_nettype none
package pife_pkg;

  localparam int MAX_SAMPLES  = 1024;
  localparam int POS_W        = $clog2(MAX_SAMPLES + 1);
  localparam int PEAK_POS_W   = $clog2(MAX_SAMPLES);

  localparam int SAMPLE_W     = 12;
  localparam int RATE_W       = 20;
  localparam int FREQ_W       = 27;
  localparam int PEAK_CNT_W   = 10;
  localparam int FRAC_W       = 8;

  localparam int PROD_W       = PEAK_CNT_W + RATE_W;
  localparam int DVD_W        = PROD_W + FRAC_W;
  localparam int STEP_W       = $clog2(DVD_W);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = RATE_W;

  typedef logic [SAMPLE_W-1:0]    sample_t;
  typedef logic [RATE_W-1:0]      rate_t;
  typedef logic [FREQ_W-1:0]      freq_t;
  typedef logic [PEAK_CNT_W-1:0]  peak_cnt_t;
  typedef logic [PEAK_POS_W-1:0]  peak_pos_t;
  typedef logic [POS_W-1:0]       position_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_PEAK_THRESHOLD = cfg_index_t'(0);
  localparam cfg_index_t REG_SAMPLE_RATE    = cfg_index_t'(1);

  localparam sample_t THRESHOLD_RESET = sample_t'(2000);
  localparam rate_t   RATE_RESET      = rate_t'(10000);

  // summary of one finished record, handed from front to back
  typedef struct packed {
    peak_cnt_t peaks;
    peak_pos_t span;
    logic      valid;
  } rec_summary_t;

endpackage
`default_nettype wire

### design/pife_sample_if.sv
`default_nettype none
interface pife_sample_if import pife_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface
`default_nettype wire

### design/pife_result_if.sv
`default_nettype none
interface pife_result_if import pife_pkg::*; ();
  logic      valid;
  logic      ready;
  freq_t     frequency_q8;
  peak_cnt_t peak_total;
  logic      estimate_valid;

  modport source (output valid, output frequency_q8, output peak_total,
                  output estimate_valid, input ready);
  modport sink   (input valid, input frequency_q8, input peak_total,
                  input estimate_valid, output ready);
endinterface
`default_nettype wire

### design/pife_front.sv
`default_nettype none
module pife_front import pife_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sample_t      threshold,
  pife_sample_if.sink       samples,
  input  wire logic         queue_full,
  output logic              push,
  output rec_summary_t      summary
);

  sample_t   older_sample;
  sample_t   middle_sample;
  position_t sample_position;
  peak_cnt_t peaks_seen;
  peak_pos_t first_peak_position;
  peak_pos_t latest_peak_position;

  logic      accept;
  logic      in_range;
  logic      is_peak;
  peak_pos_t cand;
  position_t pos_minus_one;
  peak_cnt_t peaks_next;
  peak_pos_t first_next;
  peak_pos_t latest_next;

  assign samples.ready = !queue_full;
  assign accept        = samples.valid && samples.ready;

  assign in_range      = sample_position < position_t'(MAX_SAMPLES);
  assign pos_minus_one = sample_position - position_t'(1);
  assign cand          = pos_minus_one[PEAK_POS_W-1:0];

  // the incoming word is the right neighbour of middle_sample
  assign is_peak = in_range && (sample_position >= position_t'(2)) &&
                   (middle_sample > threshold) &&
                   (middle_sample > older_sample) &&
                   (middle_sample > samples.sample);

  assign peaks_next  = is_peak ? peaks_seen + peak_cnt_t'(1) : peaks_seen;
  assign first_next  = (is_peak && peaks_seen == '0) ? cand : first_peak_position;
  assign latest_next = is_peak ? cand : latest_peak_position;

  assign push          = accept && samples.last_sample;
  assign summary.peaks = peaks_next;
  assign summary.span  = latest_next - first_next;
  assign summary.valid = (peaks_next >= peak_cnt_t'(2)) && (latest_next > first_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample         <= '0;
      middle_sample        <= '0;
      sample_position      <= '0;
      peaks_seen           <= '0;
      first_peak_position  <= '0;
      latest_peak_position <= '0;
    end else if (accept) begin
      if (samples.last_sample) begin
        // record done: clear for the next one
        older_sample         <= '0;
        middle_sample        <= '0;
        sample_position      <= '0;
        peaks_seen           <= '0;
        first_peak_position  <= '0;
        latest_peak_position <= '0;
      end else if (in_range) begin
        older_sample         <= middle_sample;
        middle_sample        <= samples.sample;
        sample_position      <= sample_position + position_t'(1);
        peaks_seen           <= peaks_next;
        first_peak_position  <= first_next;
        latest_peak_position <= latest_next;
      end
    end
  end

endmodule
`default_nettype wire

### design/pife_queue.sv
`default_nettype none
module pife_queue import pife_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire rec_summary_t push_data,
  input  wire logic         pop,
  output rec_summary_t      head,
  output logic              full,
  output logic              empty
);

  rec_summary_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/pife_back.sv
`default_nettype none
module pife_back import pife_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rate_t        rate_hz,
  input  wire rec_summary_t head,
  input  wire logic         queue_empty,
  output logic              pop,
  pife_result_if.source     results
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t               state;
  peak_cnt_t            mul_a;
  peak_pos_t            den;
  logic [PEAK_POS_W-1:0] rem;
  logic [DVD_W-1:0]     dvd;
  logic [STEP_W-1:0]    step;
  freq_t                frequency;
  peak_cnt_t            peak_total;
  logic                 estimate_valid;

  logic [PROD_W-1:0]     product;
  logic [PEAK_POS_W:0]   trial;
  logic                  ge;
  logic [PEAK_POS_W:0]   diff;
  logic [PEAK_POS_W-1:0] rem_next;
  logic [DVD_W-1:0]      dvd_next;

  assign pop     = (state == ST_IDLE) && !queue_empty;
  assign product = PROD_W'(mul_a) * PROD_W'(rate_hz);

  // one restoring divide step: quotient bits shift into dvd from the right
  assign trial    = {rem, dvd[DVD_W-1]};
  assign ge       = trial >= {1'b0, den};
  assign diff     = trial - {1'b0, den};
  assign rem_next = ge ? diff[PEAK_POS_W-1:0] : trial[PEAK_POS_W-1:0];
  assign dvd_next = {dvd[DVD_W-2:0], ge};

  assign results.valid          = state == ST_DONE;
  assign results.frequency_q8   = frequency;
  assign results.peak_total     = peak_total;
  assign results.estimate_valid = estimate_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mul_a          <= '0;
      den            <= '0;
      rem            <= '0;
      dvd            <= '0;
      step           <= '0;
      frequency      <= '0;
      peak_total     <= '0;
      estimate_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            peak_total     <= head.peaks;
            estimate_valid <= head.valid;
            den            <= head.span;
            mul_a          <= head.peaks - peak_cnt_t'(1);
            if (head.valid) begin
              state <= ST_MUL;
            end else begin
              frequency <= '0;
              state     <= ST_DONE;
            end
          end
        end
        ST_MUL: begin
          dvd   <= {product, FRAC_W'(0)};
          rem   <= '0;
          step  <= STEP_W'(DVD_W - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= rem_next;
          dvd  <= dvd_next;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            frequency <= dvd_next[FREQ_W-1:0];
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_invalid_gives_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.estimate_valid |-> results.frequency_q8 == '0)
    else $error("invalid estimate with nonzero frequency");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != '0)
    else $error("divide by zero span");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && step == '0 |=> state == ST_DONE)
    else $error("divider did not finish after last step");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(frequency))
    else $error("result dropped before taken");

endmodule
`default_nettype wire

### design/peak_interval_frequency_estimator_top.sv
// Peak-interval frequency estimator. Takes one 12-bit sample word per cycle
// when not stalled; a sample above peak_threshold and strictly above both
// neighbours is a peak (the first and last sample of a record are never tested,
// and samples past the first 1024 of a record are ignored). The word with
// last_sample set ends the record and yields one result: frequency_q8 =
// floor((peaks-1) * rate * 256 / (last_peak - first_peak)), Hz in Q.8, with
// estimate_valid low and frequency 0 for fewer than two peaks. In the back,
// each summary goes through pop, one 10x20 multiply, 38 restoring divide
// steps and output when the estimate is valid, pop and output when not, then
// waits for results.ready. A two-entry summary queue sits between front and
// back; the input stalls on any word while both queue entries hold summaries
// waiting behind the one in the back. Write config only while idle.
`default_nettype none
module peak_interval_frequency_estimator_top import pife_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire cfg_index_t cfg_index,
  input  wire cfg_data_t  cfg_wdata,
  pife_sample_if.sink     samples,
  pife_result_if.source   results
);

  sample_t      peak_threshold;
  rate_t        rate_hz;
  logic         push;
  logic         pop;
  logic         queue_full;
  logic         queue_empty;
  rec_summary_t push_data;
  rec_summary_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= THRESHOLD_RESET;
      rate_hz        <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_wdata[SAMPLE_W-1:0];
        REG_SAMPLE_RATE:    rate_hz        <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  pife_front u_front (
    .clk        (clk),
    .rst        (rst),
    .threshold  (peak_threshold),
    .samples    (samples),
    .queue_full (queue_full),
    .push       (push),
    .summary    (push_data)
  );

  pife_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  pife_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rate_hz     (rate_hz),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .results     (results)
  );

endmodule
`default_nettype wire
